### hw/rtl/saturating_blob_blend_plotter_defines.svh
// ----------------------------------------------------------------------------
// saturating_blob_blend_plotter_defines: assertion macros
// Shorthand for concurrent checks clocked on clk_i, with and without reset.
// ----------------------------------------------------------------------------
`ifndef SATURATING_BLOB_BLEND_PLOTTER_DEFINES_SVH
`define SATURATING_BLOB_BLEND_PLOTTER_DEFINES_SVH

// Check that is off while rst_ni is low.
`define SBBP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("sbbp check failed");

// Check that also holds while rst_ni is low.
`define SBBP_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("sbbp reset check failed");

`endif

### hw/rtl/sbbp_pkg.sv
// ----------------------------------------------------------------------------
// sbbp_pkg: blob plotter constants and types
// Framebuffer geometry, request kind codes and the controller state type.
// ----------------------------------------------------------------------------
package sbbp_pkg;

  localparam int FB_WIDTH  = 512;
  localparam int FB_HEIGHT = 512;
  localparam int BLOB_HALF = 2;

  localparam int FB_DEPTH    = FB_WIDTH * FB_HEIGHT;
  localparam int AW          = $clog2(FB_DEPTH);
  localparam int XW          = $clog2(FB_WIDTH);
  localparam int YW          = $clog2(FB_HEIGHT);
  localparam int BLOB_SIDE   = 2 * BLOB_HALF;
  localparam int BLOB_PIXELS = BLOB_SIDE * BLOB_SIDE;
  localparam int CW          = $clog2(BLOB_PIXELS + 1);
  localparam int SW          = $clog2(BLOB_SIDE);

  // Signed 17-bit bounds for the viewport tests.
  localparam logic signed [16:0] BLOB_X_LO = 17'(BLOB_HALF);
  localparam logic signed [16:0] BLOB_X_HI = 17'(FB_WIDTH - BLOB_HALF);
  localparam logic signed [16:0] BLOB_Y_LO = 17'(BLOB_HALF);
  localparam logic signed [16:0] BLOB_Y_HI = 17'(FB_HEIGHT - BLOB_HALF);
  localparam logic signed [16:0] PIX_X_END = 17'(FB_WIDTH);
  localparam logic signed [16:0] PIX_Y_END = 17'(FB_HEIGHT);
  localparam logic signed [16:0] POS_ZERO  = 17'sd0;

  localparam logic [1:0] KIND_PLAIN = 2'd0;
  localparam logic [1:0] KIND_HOT   = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  localparam logic [31:0] OPAQUE_BLACK = 32'hFF00_0000;
  localparam logic [7:0]  HOT_LIMIT    = 8'd248;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_BLEND,
    ST_READ,
    ST_DONE
  } state_e;

endpackage

### hw/rtl/saturating_blob_blend_plotter.sv
// ----------------------------------------------------------------------------
// saturating_blob_blend_plotter: saturating additive blob plotter, RGBA store
// Blob request: checked, then its 16 pixels are read, blended and written back
// one after another over the framebuffer read and write ports before the result
// is offered; the next request waits for this. Read request: one pixel read.
// Reset: in_stall_o stays high during a clearing sweep of all 262144 pixels.
// ----------------------------------------------------------------------------
module saturating_blob_blend_plotter (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         kind_i,
  input  logic signed [15:0] x_pos_i,
  input  logic signed [15:0] y_pos_i,
  input  logic [31:0]        color_i,
  input  logic [7:0]         opacity_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               status_o,
  output logic [31:0]        read_data_o
);

  // Saturating 8-bit add.
  function automatic logic [7:0] sat_add8(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[8] ? 8'hFF : s[7:0];
  endfunction

  // Exact floor(x / 255) for x up to 255*255.
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = {1'b0, x} + 17'(x[15:8]) + 17'd1;
    return t[15:8];
  endfunction

  // --------------------------------------------------------------------------
  // State and request registers
  // --------------------------------------------------------------------------
  sbbp_pkg::state_e state_q, state_d;

  logic [sbbp_pkg::AW-1:0] clr_q;        // clearing sweep address
  logic [sbbp_pkg::CW-1:0] cnt_q;        // blob pixel reads issued
  logic [sbbp_pkg::SW-1:0] col_q;        // column offset inside the blob
  logic [sbbp_pkg::AW-1:0] row_addr_q;   // address of current blob row (or read pixel)
  logic                    wr_pend_q;    // blended pixel due for write-back
  logic [sbbp_pkg::AW-1:0] wr_addr_q;

  // Captured request (payload, no reset)
  logic [1:0]         kind_q;
  logic signed [15:0] x_q, y_q;
  logic [31:0]        color_q;
  logic [7:0]         opacity_q;

  // Per-request channel contributions, computed once in the check cycle
  logic [7:0] ctr_r_q, ctr_g_q, ctr_b_q, ctr_hg_q;

  // Result being assembled
  logic res_status_q;
  logic res_rd_q;

  // Output register
  logic        out_valid_q;
  logic        status_q;
  logic [31:0] read_data_q;

  // Framebuffer memory
  logic [31:0]             fb_mem [sbbp_pkg::FB_DEPTH];
  logic [31:0]             rd_data_q;
  logic                    rd_en, wr_en;
  logic [sbbp_pkg::AW-1:0] rd_addr, wr_addr;
  logic [31:0]             wr_data;

  // --------------------------------------------------------------------------
  // Request decode and viewport tests on the captured request
  // --------------------------------------------------------------------------
  logic signed [16:0] xs, ys;
  logic               is_blend, is_read, blob_fit, pix_in;
  logic               blend_go, read_go;
  logic               in_accept, out_free, blob_last;

  assign xs = {x_q[15], x_q};
  assign ys = {y_q[15], y_q};

  assign is_blend = (kind_q == sbbp_pkg::KIND_PLAIN) || (kind_q == sbbp_pkg::KIND_HOT);
  assign is_read  = (kind_q == sbbp_pkg::KIND_READ);

  // Blob must sit BLOB_HALF inside every edge.
  assign blob_fit = (xs >= sbbp_pkg::BLOB_X_LO) && (xs < sbbp_pkg::BLOB_X_HI) &&
                    (ys >= sbbp_pkg::BLOB_Y_LO) && (ys < sbbp_pkg::BLOB_Y_HI);
  assign pix_in   = (xs >= sbbp_pkg::POS_ZERO) && (xs < sbbp_pkg::PIX_X_END) &&
                    (ys >= sbbp_pkg::POS_ZERO) && (ys < sbbp_pkg::PIX_Y_END);

  assign blend_go = is_blend && blob_fit;
  assign read_go  = is_read && pix_in;

  assign in_accept = in_valid_i && !in_stall_o;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign blob_last = (cnt_q == sbbp_pkg::CW'(sbbp_pkg::BLOB_PIXELS));

  // Start address: top-left blob corner for a blend, the pixel for a read.
  logic signed [15:0]      x_corner, y_corner;
  logic [sbbp_pkg::XW-1:0] col_sel;
  logic [sbbp_pkg::YW-1:0] row_sel;
  logic [sbbp_pkg::AW-1:0] base_addr;

  assign x_corner = x_q - 16'(sbbp_pkg::BLOB_HALF);
  assign y_corner = y_q - 16'(sbbp_pkg::BLOB_HALF);
  assign col_sel  = is_read ? x_q[sbbp_pkg::XW-1:0] : x_corner[sbbp_pkg::XW-1:0];
  assign row_sel  = is_read ? y_q[sbbp_pkg::YW-1:0] : y_corner[sbbp_pkg::YW-1:0];
  assign base_addr = sbbp_pkg::AW'(row_sel) * sbbp_pkg::AW'(sbbp_pkg::FB_WIDTH)
                   + sbbp_pkg::AW'(col_sel);

  // --------------------------------------------------------------------------
  // Next-state logic
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sbbp_pkg::ST_CLEAR: begin
        if (clr_q == sbbp_pkg::AW'(sbbp_pkg::FB_DEPTH - 1)) state_d = sbbp_pkg::ST_IDLE;
      end
      sbbp_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = sbbp_pkg::ST_CHECK;
      end
      sbbp_pkg::ST_CHECK: begin
        if (blend_go)     state_d = sbbp_pkg::ST_BLEND;
        else if (read_go) state_d = sbbp_pkg::ST_READ;
        else              state_d = sbbp_pkg::ST_DONE;
      end
      sbbp_pkg::ST_BLEND: begin
        if (blob_last) state_d = sbbp_pkg::ST_DONE;
      end
      sbbp_pkg::ST_READ: begin
        state_d = sbbp_pkg::ST_DONE;
      end
      sbbp_pkg::ST_DONE: begin
        if (out_free) state_d = sbbp_pkg::ST_IDLE;
      end
      default: state_d = sbbp_pkg::ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Blend datapath: stored pixel is registered and arrives in the cycle after its read.
  // --------------------------------------------------------------------------
  logic [7:0]  px_r, px_g, px_b, new_r, new_g, new_b;
  logic        hot_divert;
  logic [31:0] blend_word;

  assign px_r = rd_data_q[7:0];
  assign px_g = rd_data_q[15:8];
  assign px_b = rd_data_q[23:16];

  // Hot mode: saturated-looking blue spills into green at half opacity.
  assign hot_divert = (kind_q == sbbp_pkg::KIND_HOT) && (px_b > sbbp_pkg::HOT_LIMIT);

  assign new_r = sat_add8(px_r, ctr_r_q);
  assign new_g = hot_divert ? sat_add8(px_g, ctr_hg_q) : sat_add8(px_g, ctr_g_q);
  assign new_b = hot_divert ? px_b : sat_add8(px_b, ctr_b_q);

  assign blend_word = {color_q[31:24], new_b, new_g, new_r};

  // --------------------------------------------------------------------------
  // Output logic: memory port control and handshake
  // --------------------------------------------------------------------------
  always_comb begin
    in_stall_o = 1'b1;
    rd_en      = 1'b0;
    rd_addr    = row_addr_q + sbbp_pkg::AW'(col_q);
    wr_en      = wr_pend_q;
    wr_addr    = wr_addr_q;
    wr_data    = blend_word;
    unique case (state_q)
      sbbp_pkg::ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
        wr_data = sbbp_pkg::OPAQUE_BLACK;
      end
      sbbp_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
      end
      sbbp_pkg::ST_BLEND: begin
        rd_en = !blob_last;
      end
      sbbp_pkg::ST_READ: begin
        rd_en   = 1'b1;
        rd_addr = row_addr_q;
      end
      default: begin
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Framebuffer: one write and one registered read per cycle. Blob pixels are
  // distinct and requests run one at a time, so a read never meets a pending
  // write to the same entry.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (wr_en) fb_mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_q <= fb_mem[rd_addr];
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sbbp_pkg::ST_CLEAR;
      clr_q       <= '0;
      cnt_q       <= '0;
      col_q       <= '0;
      wr_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      if (state_q == sbbp_pkg::ST_CLEAR) clr_q <= clr_q + sbbp_pkg::AW'(1);

      if (state_q == sbbp_pkg::ST_CHECK) begin
        cnt_q <= '0;
        col_q <= '0;
      end else if (state_q == sbbp_pkg::ST_BLEND && !blob_last) begin
        cnt_q <= cnt_q + sbbp_pkg::CW'(1);
        if (col_q == sbbp_pkg::SW'(sbbp_pkg::BLOB_SIDE - 1)) col_q <= '0;
        else                                                  col_q <= col_q + sbbp_pkg::SW'(1);
      end

      // Write-back follows each blob read in the next cycle.
      wr_pend_q <= (state_q == sbbp_pkg::ST_BLEND) && !blob_last;

      if (state_q == sbbp_pkg::ST_DONE && out_free) out_valid_q <= 1'b1;
      else if (!out_stall_i)                       out_valid_q <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      kind_q    <= kind_i;
      x_q       <= x_pos_i;
      y_q       <= y_pos_i;
      color_q   <= color_i;
      opacity_q <= opacity_i;
    end

    if (state_q == sbbp_pkg::ST_CHECK) begin
      // One 8x8 product per channel, then an exact divide by 255.
      ctr_r_q      <= div255(16'(color_q[7:0])   * 16'(opacity_q));
      ctr_g_q      <= div255(16'(color_q[15:8])  * 16'(opacity_q));
      ctr_b_q      <= div255(16'(color_q[23:16]) * 16'(opacity_q));
      ctr_hg_q     <= div255(16'(color_q[23:16]) * 16'(opacity_q >> 1));
      res_status_q <= !(blend_go || read_go);
      res_rd_q     <= read_go;
    end

    if (state_q == sbbp_pkg::ST_CHECK) begin
      row_addr_q <= base_addr;
    end else if (state_q == sbbp_pkg::ST_BLEND && !blob_last &&
                 col_q == sbbp_pkg::SW'(sbbp_pkg::BLOB_SIDE - 1)) begin
      row_addr_q <= row_addr_q + sbbp_pkg::AW'(sbbp_pkg::FB_WIDTH);
    end

    wr_addr_q <= rd_addr;

    // rd_data_q holds the read pixel until the result is loaded.
    if (state_q == sbbp_pkg::ST_DONE && out_free) begin
      status_q    <= res_status_q;
      read_data_q <= res_rd_q ? rd_data_q : 32'd0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign read_data_o = read_data_q;

endmodule

### hw/rtl/sbbp_checker.sv
// ----------------------------------------------------------------------------
// sbbp_checker: port-level checks for the blob plotter
// Watches the request and result channels of the top level.
// ----------------------------------------------------------------------------
`include "saturating_blob_blend_plotter_defines.svh"

module sbbp_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic [1:0]         kind_i,
  input logic signed [15:0] x_pos_i,
  input logic signed [15:0] y_pos_i,
  input logic [31:0]        color_i,
  input logic [7:0]         opacity_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic               status_o,
  input logic [31:0]        read_data_o
);

  // Stalled result stays offered and unchanged.
  `SBBP_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o))
  `SBBP_ASSERT(a_out_data_hold, out_valid_o && out_stall_i |=> $stable(read_data_o))

  // A rejected request never returns pixel data.
  `SBBP_ASSERT(a_reject_zero, out_valid_o && status_o |-> read_data_o == 32'd0)

  // One request at a time: an accepted request closes the input channel.
  `SBBP_ASSERT(a_one_at_a_time, in_valid_i && !in_stall_o |=> in_stall_o)

  // No request is taken and no result shown while in reset.
  `SBBP_ASSERT_RST(a_reset_quiet, !rst_ni |-> in_stall_o && !out_valid_o)

endmodule

bind saturating_blob_blend_plotter sbbp_checker u_sbbp_checker (.*);

### sim/sbbp_result_check.sv
// ----------------------------------------------------------------------------
// sbbp_result_check: response checker for the blob plotter
// Keeps a shadow framebuffer, predicts status and read data for every
// accepted request and compares each accepted response against the oldest
// prediction in order.
// ----------------------------------------------------------------------------
module sbbp_result_check (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [1:0]         kind_i,
  input  logic signed [15:0] x_pos_i,
  input  logic signed [15:0] y_pos_i,
  input  logic [31:0]        color_i,
  input  logic [7:0]         opacity_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic               status_i,
  input  logic [31:0]        read_data_i,
  output int                 mismatch_cnt_o,
  output int                 pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        status;
    logic [31:0] read_data;
  } plot_answer_t;

  bit [31:0]    fb_shadow [sbbp_pkg::FB_DEPTH];
  plot_answer_t answer_q[$];
  int           mismatch_cnt = 0;
  int           pending = 0;

  assign mismatch_cnt_o = mismatch_cnt;
  assign pending_o      = pending;

  initial begin
    for (int i = 0; i < sbbp_pkg::FB_DEPTH; i++) fb_shadow[i] = sbbp_pkg::OPAQUE_BLACK;
  end

  // stored + c*weight/255, clipped at full scale
  function automatic logic [7:0] chan_add(input logic [7:0] stored, input logic [7:0] c,
                                          input logic [7:0] weight);
    int s;
    s = int'(stored) + (int'(c) * int'(weight)) / 255;
    return (s > 255) ? 8'd255 : s[7:0];
  endfunction

  // Applies one request to the shadow framebuffer and returns its response.
  function automatic plot_answer_t plot_apply(input logic [1:0] kind,
                                              input logic signed [15:0] x,
                                              input logic signed [15:0] y,
                                              input logic [31:0] color,
                                              input logic [7:0] opacity);
    plot_answer_t ans;
    int           xc, yc, cx, cy, idx;
    logic [31:0]  p;
    logic [7:0]   r, g, b;
    ans.status    = 1'b1;
    ans.read_data = '0;
    xc = x;
    yc = y;
    case (kind) inside
      sbbp_pkg::KIND_PLAIN, sbbp_pkg::KIND_HOT: begin
        if (xc - sbbp_pkg::BLOB_HALF >= 0 && xc + sbbp_pkg::BLOB_HALF < sbbp_pkg::FB_WIDTH &&
            yc - sbbp_pkg::BLOB_HALF >= 0 && yc + sbbp_pkg::BLOB_HALF < sbbp_pkg::FB_HEIGHT)
        begin
          for (cx = xc - sbbp_pkg::BLOB_HALF; cx < xc + sbbp_pkg::BLOB_HALF; cx++) begin
            for (cy = yc - sbbp_pkg::BLOB_HALF; cy < yc + sbbp_pkg::BLOB_HALF; cy++) begin
              idx = cx + cy * sbbp_pkg::FB_WIDTH;
              p   = fb_shadow[idx];
              r   = chan_add(p[7:0], color[7:0], opacity);
              // hot pixel: blue is frozen and spills into green at half weight
              if (kind == sbbp_pkg::KIND_HOT && p[23:16] > sbbp_pkg::HOT_LIMIT) begin
                g = chan_add(p[15:8], color[23:16], opacity >> 1);
                b = p[23:16];
              end else begin
                g = chan_add(p[15:8], color[15:8], opacity);
                b = chan_add(p[23:16], color[23:16], opacity);
              end
              fb_shadow[idx] = {color[31:24], b, g, r};
            end
          end
          ans.status = 1'b0;
        end
      end
      sbbp_pkg::KIND_READ: begin
        if (xc >= 0 && xc < sbbp_pkg::FB_WIDTH && yc >= 0 && yc < sbbp_pkg::FB_HEIGHT) begin
          ans.read_data = fb_shadow[xc + yc * sbbp_pkg::FB_WIDTH];
          ans.status    = 1'b0;
        end
      end
      default: ;
    endcase
    return ans;
  endfunction

  always @(posedge clk_i) begin : watch
    plot_answer_t want;
    if (rst_ni) begin
      // response side first: a request accepted on this edge is never answered on it
      if (out_valid_i && !out_stall_i) begin
        if (answer_q.size() == 0) begin
          mismatch_cnt++;
          $display("%0t: unexpected response, expected none, actual status %0d data %h",
                   $time, status_i, read_data_i);
        end else begin
          want = answer_q.pop_front();
          if (status_i !== want.status) begin
            mismatch_cnt++;
            $display("%0t: status expected %0d actual %0d", $time, want.status, status_i);
          end
          if (read_data_i !== want.read_data) begin
            mismatch_cnt++;
            $display("%0t: read_data expected %h actual %h", $time, want.read_data,
                     read_data_i);
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        answer_q.push_back(plot_apply(kind_i, x_pos_i, y_pos_i, color_i, opacity_i));
      pending = answer_q.size();
    end
  end

endmodule

### sim/tb_saturating_blob_blend_plotter.sv
// ----------------------------------------------------------------------------
// tb_saturating_blob_blend_plotter: testbench top for the blob plotter
// Directed edge cases, then random blend, hot-blend and read requests with
// bursty idling on both channels; a separate checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_saturating_blob_blend_plotter;
  timeunit 1ns;
  timeprecision 1ps;

  // kind code with no defined action: must be answered as rejected
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam int RAND_REQS     = 1926;
  localparam int QUIET_TAIL    = 200;   // last requests run with no idling
  localparam int HOLD_AT       = 600;   // long response hold-off starts here
  localparam int DRAIN_AT      = 1200;  // sender waits for an empty pipe here
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_CAP     = 5000;
  localparam int SETTLE_CYCLES = 40;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [1:0]         kind_i;
  logic signed [15:0] x_pos_i;
  logic signed [15:0] y_pos_i;
  logic [31:0]        color_i;
  logic [7:0]         opacity_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic               status_o;
  logic [31:0]        read_data_o;

  int mismatch_cnt;
  int pending;

  // idling rates in percent, re-picked now and then so that some stretches
  // run back to back and others are choppy
  int tx_pct = 15;
  int rx_pct = 15;
  bit quiet = 1'b0;     // no idling on either side
  bit hold_out = 1'b0;  // asks the response side for a long hold-off

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  saturating_blob_blend_plotter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .kind_i      (kind_i),
    .x_pos_i     (x_pos_i),
    .y_pos_i     (y_pos_i),
    .color_i     (color_i),
    .opacity_i   (opacity_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .read_data_o (read_data_o)
  );

  sbbp_result_check result_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .kind_i         (kind_i),
    .x_pos_i        (x_pos_i),
    .y_pos_i        (y_pos_i),
    .color_i        (color_i),
    .opacity_i      (opacity_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_i       (status_o),
    .read_data_i    (read_data_o),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_o      (pending)
  );

  // Offers one request and holds it until the plotter takes it. Called right
  // after a rising edge; returns right after one, optionally after an idle burst.
  task automatic send_req(input logic [1:0] kind, input logic signed [15:0] x,
                          input logic signed [15:0] y, input logic [31:0] color,
                          input logic [7:0] opacity);
    in_valid_i <= 1'b1;
    kind_i     <= kind;
    x_pos_i    <= x;
    y_pos_i    <= y;
    color_i    <= color;
    opacity_i  <= opacity;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if ($urandom_range(0, 63) == 0) tx_pct = $urandom_range(0, 2) * 15;
    if (!quiet && $urandom_range(0, 99) < tx_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  endtask

  // Waits until the checker has no outstanding prediction, with a cap.
  // The first edge lets a push from the last acceptance show up in the count.
  task automatic wait_drained();
    int n;
    n = 0;
    @(posedge clk_i);
    while (pending != 0 && n < DRAIN_CAP) begin
      @(posedge clk_i);
      n++;
    end
  endtask

  // Coordinates: mostly a small corner window so blobs pile up, saturate and
  // turn hot; then the viewport edges, anywhere in frame, and any 16-bit value.
  function automatic logic signed [15:0] pick_coord(input bit is_read, input int limit);
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 65)
      return is_read ? 16'($urandom_range(0, 21)) : 16'($urandom_range(0, 19));
    if (sel < 80) begin
      if ($urandom_range(0, 1) == 0) return 16'($urandom_range(0, 5) - 2);
      return 16'($urandom_range(limit - 4, limit + 1));
    end
    if (sel < 90) return 16'($urandom_range(0, limit - 1));
    return 16'($urandom());
  endfunction

  // Colors: often a blue above the hot threshold, otherwise anything.
  function automatic logic [31:0] pick_color();
    logic [31:0] c;
    c = $urandom();
    if ($urandom_range(0, 99) < 30) c[23:16] = 8'($urandom_range(249, 255));
    return c;
  endfunction

  function automatic logic [7:0] pick_opacity();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 15) return 8'd255;
    if (sel < 25) return 8'd0;
    if (sel < 30) return 8'd1;
    return 8'($urandom_range(0, 255));
  endfunction

  // Response side: random stall bursts, plus one long hold-off on request.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if ($urandom_range(0, 63) == 0) rx_pct = $urandom_range(0, 2) * 15;
      if (hold_out) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_out = 1'b0;
        out_stall_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < rx_pct) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Request side: directed cases, random traffic, drain and verdict.
  initial begin
    logic [1:0] kind;
    int         sel;
    rst_ni     = 1'b1;
    in_valid_i = 1'b0;
    kind_i     = sbbp_pkg::KIND_PLAIN;
    x_pos_i    = '0;
    y_pos_i    = '0;
    color_i    = '0;
    opacity_i  = '0;
    // clean falling edge on reset, well before the first clock edge
    #1 rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // the clearing sweep after reset is absorbed by the input handshake
    // smallest legal blob, full weight on a cleared pixel, then saturation
    send_req(sbbp_pkg::KIND_PLAIN, 16'sd2, 16'sd2, 32'h80FF_FFFF, 8'd255);
    send_req(sbbp_pkg::KIND_PLAIN, 16'sd2, 16'sd2, 32'h1234_5678, 8'd255);
    send_req(sbbp_pkg::KIND_READ, 16'sd0, 16'sd0, 32'h0, 8'd0);
    send_req(sbbp_pkg::KIND_READ, 16'sd3, 16'sd3, 32'hFFFF_FFFF, 8'd255);
    // largest legal blob, zero weight: only the alpha byte changes
    send_req(sbbp_pkg::KIND_PLAIN, 16'sd509, 16'sd509, 32'hFFFF_FFFF, 8'd0);
    send_req(sbbp_pkg::KIND_READ, 16'sd511, 16'sd511, 32'h0, 8'd0);
    // one pixel past each viewport margin, then the extremes of the range
    send_req(sbbp_pkg::KIND_PLAIN, 16'sd1, 16'sd2, 32'hFFFF_FFFF, 8'd255);
    send_req(sbbp_pkg::KIND_HOT, 16'sd2, 16'sd1, 32'hFFFF_FFFF, 8'd255);
    send_req(sbbp_pkg::KIND_PLAIN, 16'sd510, 16'sd509, 32'hFFFF_FFFF, 8'd255);
    send_req(sbbp_pkg::KIND_PLAIN, 16'sd509, 16'sd510, 32'hFFFF_FFFF, 8'd255);
    send_req(sbbp_pkg::KIND_HOT, -16'sd32768, 16'sd32767, 32'hFFFF_FFFF, 8'd255);
    send_req(sbbp_pkg::KIND_PLAIN, 16'sd32767, -16'sd32768, 32'hFFFF_FFFF, 8'd255);
    // hot threshold: blue exactly at the limit blends normally, a saturated blue spills
    send_req(sbbp_pkg::KIND_PLAIN, 16'sd20, 16'sd20, 32'h00F8_0000, 8'd255);
    send_req(sbbp_pkg::KIND_HOT, 16'sd20, 16'sd20, 32'hAAF0_4010, 8'd200);
    send_req(sbbp_pkg::KIND_PLAIN, 16'sd20, 16'sd20, 32'h0001_0000, 8'd255);
    send_req(sbbp_pkg::KIND_HOT, 16'sd20, 16'sd20, 32'h55FF_8001, 8'd255);
    send_req(sbbp_pkg::KIND_READ, 16'sd19, 16'sd19, 32'h0, 8'd0);
    // reads just outside the frame on each side
    send_req(sbbp_pkg::KIND_READ, 16'sd512, 16'sd0, 32'h0, 8'd0);
    send_req(sbbp_pkg::KIND_READ, 16'sd0, 16'sd512, 32'h0, 8'd0);
    send_req(sbbp_pkg::KIND_READ, -16'sd1, 16'sd5, 32'h0, 8'd0);
    send_req(sbbp_pkg::KIND_READ, 16'sd5, -16'sd1, 32'h0, 8'd0);
    // undefined kind is rejected and leaves the picture alone
    send_req(KIND_UNUSED, 16'sd10, 16'sd10, 32'hFFFF_FFFF, 8'd255);
    // smallest nonzero weight
    send_req(sbbp_pkg::KIND_PLAIN, 16'sd100, 16'sd200, 32'hFFFF_FFFF, 8'd1);
    send_req(sbbp_pkg::KIND_READ, 16'sd99, 16'sd199, 32'h0, 8'd0);

    for (int n = 0; n < RAND_REQS; n++) begin
      if (n == HOLD_AT) hold_out = 1'b1;  // sender keeps offering meanwhile
      if (n == DRAIN_AT) begin
        in_valid_i <= 1'b0;
        wait_drained();
      end
      if (n == RAND_REQS - QUIET_TAIL) quiet = 1'b1;
      sel = $urandom_range(0, 99);
      if (sel < 40) kind = sbbp_pkg::KIND_PLAIN;
      else if (sel < 65) kind = sbbp_pkg::KIND_HOT;
      else if (sel < 95) kind = sbbp_pkg::KIND_READ;
      else kind = KIND_UNUSED;
      send_req(kind, pick_coord(kind == sbbp_pkg::KIND_READ, sbbp_pkg::FB_WIDTH),
               pick_coord(kind == sbbp_pkg::KIND_READ, sbbp_pkg::FB_HEIGHT), pick_color(),
               pick_opacity());
    end
    in_valid_i <= 1'b0;

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog: clearing sweep plus all traffic at its slowest, several times over.
  initial begin
    #15_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
